// ----- design/ftlgc_pkg.sv -----
package ftlgc_pkg;

  localparam int LOGICAL_PAGES   = 64;
  localparam int BLOCK_COUNT     = 16;
  localparam int PAGES_PER_BLOCK = 16;
  localparam int PHYS_PAGES      = BLOCK_COUNT * PAGES_PER_BLOCK;

  localparam int LP_W  = (LOGICAL_PAGES > 1) ? $clog2(LOGICAL_PAGES) : 1;
  localparam int BLK_W = $clog2(BLOCK_COUNT);
  localparam int PG_W  = (PAGES_PER_BLOCK > 1) ? $clog2(PAGES_PER_BLOCK) : 1;
  localparam int PA_W  = $clog2(PHYS_PAGES);
  localparam int CNT_W = $clog2(PAGES_PER_BLOCK + 1);

  typedef logic [LP_W-1:0]  lp_t;
  typedef logic [BLK_W-1:0] blk_t;
  typedef logic [PG_W-1:0]  pg_t;
  typedef logic [BLK_W:0]   blkc_t;
  typedef logic [PG_W:0]    pgc_t;
  typedef logic [PA_W-1:0]  pa_t;
  typedef logic [CNT_W-1:0] cnt_t;

  typedef struct packed {
    blk_t blk;
    pg_t  pg;
  } loc_t;

  typedef enum logic [1:0] {
    PS_FREE    = 2'd0,
    PS_VALID   = 2'd1,
    PS_INVALID = 2'd2
  } pstat_t;

  typedef enum logic [1:0] {
    RK_READ  = 2'd0,
    RK_WRITE = 2'd1,
    RK_MOVE  = 2'd2,
    RK_ERASE = 2'd3
  } rkind_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_RANGE  = 2'd1,
    ST_UNMAP  = 2'd2,
    ST_NOFREE = 2'd3
  } status_t;

  localparam logic KIND_READ = 1'b0;

  typedef enum logic [1:0] {
    CTX_W1,
    CTX_GC,
    CTX_W2
  } ctx_t;

  typedef enum logic [4:0] {
    S_CLR,
    S_IDLE,
    S_START,
    S_RD_W,
    S_RD_ANS,
    S_WINV_W,
    S_WINV,
    S_FF_ISS,
    S_FF_CHK,
    S_PLACE,
    S_NOFREE,
    S_VS_ISS,
    S_VS_CHK,
    S_MV_ISS,
    S_MV_CHK,
    S_MV_DO,
    S_MV_SRC,
    S_ER_ISS,
    S_ER_CHK,
    S_ER_EMIT
  } state_t;

  function automatic pa_t phys_addr(input logic [31:0] b, input logic [31:0] p);
    return PA_W'(b * PAGES_PER_BLOCK + p);
  endfunction

  function automatic logic [3:0] nib(input logic [31:0] v);
    return v[3:0];
  endfunction

endpackage

// ----- design/ftlgc_ram.sv -----
module ftlgc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ----- design/ftl_page_map_greedy_gc.sv -----
// page-mapping flash translation layer with greedy garbage collection
// input channel: in_valid / in_stall with in_kind (0 read, 1 write) and
//   in_logical_page; one request is taken only while the block is idle
// result channel: out_valid / out_stall, one result per accepted transfer,
//   out_last marks the final result of a request
// a read gives one result; a write examines pages with the free-page scan
//   until it finds a free page
// when no page is free, garbage collection runs: the victim scan reads every
//   physical page, each page move repeats the free-page scan, and the erase
//   walks the victim block page by page
// all scans go through the single read port of the page status memory
// after reset the page status memory is cleared, one page a cycle, while
//   in_stall stays high
// results sit in an output register; while the receiver stalls, the
//   sequencer holds before its next result and the register keeps its data
module ftl_page_map_greedy_gc (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_kind,
  input  logic [7:0] in_logical_page,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] out_result_kind,
  output logic [1:0] out_status,
  output logic [3:0] out_phys_block,
  output logic [3:0] out_phys_page,
  output logic [3:0] out_source_block,
  output logic [3:0] out_source_page,
  output logic       out_last
);
  import ftlgc_pkg::*;

  state_t state_r, state_nxt;
  ctx_t   ctx_r, ctx_nxt;
  logic   kind_r, kind_nxt;
  logic [7:0] lp_r, lp_nxt;
  pa_t    clr_r, clr_nxt;
  blkc_t  fb_r, fb_nxt;
  pgc_t   fp_r, fp_nxt;
  logic   skip_r, skip_nxt;
  loc_t   dst_r, dst_nxt;
  blk_t   vb_r, vb_nxt;
  pgc_t   vp_r, vp_nxt;
  cnt_t   cnt_r, cnt_nxt;
  cnt_t   best_r, best_nxt;
  blk_t   vic_r, vic_nxt;
  logic   first_r, first_nxt;
  pgc_t   mpg_r, mpg_nxt;
  lp_t    own_r, own_nxt;
  logic [LOGICAL_PAGES-1:0] mval_r, mval_nxt;

  logic       ov_r, ov_nxt;
  logic [1:0] ok_r, ok_nxt, os_r, os_nxt;
  logic [3:0] ob_r, ob_nxt, op_r, op_nxt, osb_r, osb_nxt, osp_r, osp_nxt;
  logic       ol_r, ol_nxt;

  logic   ps_we;
  pa_t    ps_waddr, ps_raddr;
  pstat_t ps_wdata;
  logic [1:0] ps_rd;
  logic   rv_we;
  pa_t    rv_waddr, rv_raddr;
  lp_t    rv_wdata, rv_rd;
  logic   mp_we;
  lp_t    mp_waddr, mp_raddr;
  loc_t   mp_wdata, mp_rd;

  logic   out_free, emit;
  logic [1:0] e_kind, e_stat;
  logic [3:0] e_blk, e_pg, e_sblk, e_spg;
  logic   e_last;
  lp_t    lpi;
  cnt_t   cinc;

  ftlgc_ram #(.WIDTH(2), .DEPTH(PHYS_PAGES)) u_ps (
    .clk(clk), .we(ps_we), .waddr(ps_waddr), .wdata(ps_wdata),
    .raddr(ps_raddr), .rdata(ps_rd)
  );
  ftlgc_ram #(.WIDTH(LP_W), .DEPTH(PHYS_PAGES)) u_rv (
    .clk(clk), .we(rv_we), .waddr(rv_waddr), .wdata(rv_wdata),
    .raddr(rv_raddr), .rdata(rv_rd)
  );
  ftlgc_ram #(.WIDTH($bits(loc_t)), .DEPTH(LOGICAL_PAGES)) u_mp (
    .clk(clk), .we(mp_we), .waddr(mp_waddr), .wdata(mp_wdata),
    .raddr(mp_raddr), .rdata(mp_rd)
  );

  assign lpi      = lp_r[LP_W-1:0];
  assign out_free = !ov_r || !out_stall;
  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    ctx_nxt   = ctx_r;
    kind_nxt  = kind_r;
    lp_nxt    = lp_r;
    clr_nxt   = clr_r;
    fb_nxt    = fb_r;
    fp_nxt    = fp_r;
    skip_nxt  = skip_r;
    dst_nxt   = dst_r;
    vb_nxt    = vb_r;
    vp_nxt    = vp_r;
    cnt_nxt   = cnt_r;
    best_nxt  = best_r;
    vic_nxt   = vic_r;
    first_nxt = first_r;
    mpg_nxt   = mpg_r;
    own_nxt   = own_r;
    mval_nxt  = mval_r;
    ps_we     = 1'b0;
    ps_waddr  = '0;
    ps_wdata  = PS_FREE;
    ps_raddr  = '0;
    rv_we     = 1'b0;
    rv_waddr  = '0;
    rv_wdata  = '0;
    rv_raddr  = '0;
    mp_we     = 1'b0;
    mp_waddr  = '0;
    mp_wdata  = '0;
    mp_raddr  = lpi;
    emit      = 1'b0;
    e_kind    = RK_READ;
    e_stat    = ST_OK;
    e_blk     = '0;
    e_pg      = '0;
    e_sblk    = '0;
    e_spg     = '0;
    e_last    = 1'b0;
    cinc      = cnt_r + ((ps_rd == PS_INVALID) ? CNT_W'(1) : CNT_W'(0));

    unique case (state_r)
      S_CLR: begin
        ps_we    = 1'b1;
        ps_waddr = clr_r;
        ps_wdata = PS_FREE;
        clr_nxt  = clr_r + PA_W'(1);
        if (clr_r == PA_W'(PHYS_PAGES - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          kind_nxt  = in_kind;
          lp_nxt    = in_logical_page;
          state_nxt = S_START;
        end
      end
      S_START: begin
        if (32'(lp_r) >= LOGICAL_PAGES) begin
          if (out_free) begin
            emit      = 1'b1;
            e_kind    = (kind_r == KIND_READ) ? RK_READ : RK_WRITE;
            e_stat    = ST_RANGE;
            e_last    = 1'b1;
            state_nxt = S_IDLE;
          end
        end else if (kind_r == KIND_READ) begin
          if (mval_r[lpi]) begin
            state_nxt = S_RD_W;
          end else if (out_free) begin
            emit      = 1'b1;
            e_kind    = RK_READ;
            e_stat    = ST_UNMAP;
            e_last    = 1'b1;
            state_nxt = S_IDLE;
          end
        end else if (mval_r[lpi]) begin
          state_nxt = S_WINV_W;
        end else begin
          fb_nxt    = '0;
          fp_nxt    = '0;
          skip_nxt  = 1'b0;
          ctx_nxt   = CTX_W1;
          state_nxt = S_FF_ISS;
        end
      end
      S_RD_W: begin
        state_nxt = S_RD_ANS;
      end
      S_RD_ANS: begin
        if (out_free) begin
          emit      = 1'b1;
          e_kind    = RK_READ;
          e_stat    = ST_OK;
          e_blk     = nib(32'(mp_rd.blk));
          e_pg      = nib(32'(mp_rd.pg));
          e_last    = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_WINV_W: begin
        state_nxt = S_WINV;
      end
      S_WINV: begin
        ps_we          = 1'b1;
        ps_waddr       = phys_addr(32'(mp_rd.blk), 32'(mp_rd.pg));
        ps_wdata       = PS_INVALID;
        mval_nxt[lpi]  = 1'b0;
        fb_nxt         = '0;
        fp_nxt         = '0;
        skip_nxt       = 1'b0;
        ctx_nxt        = CTX_W1;
        state_nxt      = S_FF_ISS;
      end
      S_FF_ISS: begin
        if (fb_r == (BLK_W + 1)'(BLOCK_COUNT)) begin
          unique case (ctx_r)
            CTX_W1: begin
              vb_nxt    = '0;
              vp_nxt    = '0;
              cnt_nxt   = '0;
              first_nxt = 1'b1;
              state_nxt = S_VS_ISS;
            end
            CTX_GC: begin
              mpg_nxt   = mpg_r + (PG_W + 1)'(1);
              state_nxt = S_MV_ISS;
            end
            default: begin
              state_nxt = S_NOFREE;
            end
          endcase
        end else if (skip_r && (fb_r[BLK_W-1:0] == vic_r)) begin
          fb_nxt = fb_r + (BLK_W + 1)'(1);
          fp_nxt = '0;
        end else begin
          ps_raddr  = phys_addr(32'(fb_r), 32'(fp_r));
          state_nxt = S_FF_CHK;
        end
      end
      S_FF_CHK: begin
        if (ps_rd == PS_FREE) begin
          dst_nxt.blk = fb_r[BLK_W-1:0];
          dst_nxt.pg  = fp_r[PG_W-1:0];
          state_nxt   = (ctx_r == CTX_GC) ? S_MV_DO : S_PLACE;
        end else begin
          if (fp_r == (PG_W + 1)'(PAGES_PER_BLOCK - 1)) begin
            fb_nxt = fb_r + (BLK_W + 1)'(1);
            fp_nxt = '0;
          end else begin
            fp_nxt = fp_r + (PG_W + 1)'(1);
          end
          state_nxt = S_FF_ISS;
        end
      end
      S_PLACE: begin
        if (out_free) begin
          ps_we         = 1'b1;
          ps_waddr      = phys_addr(32'(dst_r.blk), 32'(dst_r.pg));
          ps_wdata      = PS_VALID;
          rv_we         = 1'b1;
          rv_waddr      = ps_waddr;
          rv_wdata      = lpi;
          mp_we         = 1'b1;
          mp_waddr      = lpi;
          mp_wdata      = dst_r;
          mval_nxt[lpi] = 1'b1;
          emit          = 1'b1;
          e_kind        = RK_WRITE;
          e_stat        = ST_OK;
          e_blk         = nib(32'(dst_r.blk));
          e_pg          = nib(32'(dst_r.pg));
          e_last        = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_NOFREE: begin
        if (out_free) begin
          emit      = 1'b1;
          e_kind    = RK_WRITE;
          e_stat    = ST_NOFREE;
          e_last    = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_VS_ISS: begin
        ps_raddr  = phys_addr(32'(vb_r), 32'(vp_r));
        state_nxt = S_VS_CHK;
      end
      S_VS_CHK: begin
        state_nxt = S_VS_ISS;
        if (vp_r == (PG_W + 1)'(PAGES_PER_BLOCK - 1)) begin
          if (first_r || (cinc > best_r)) begin
            best_nxt = cinc;
            vic_nxt  = vb_r;
          end
          first_nxt = 1'b0;
          cnt_nxt   = '0;
          vp_nxt    = '0;
          if (vb_r == BLK_W'(BLOCK_COUNT - 1)) begin
            mpg_nxt   = '0;
            state_nxt = S_MV_ISS;
          end else begin
            vb_nxt = vb_r + BLK_W'(1);
          end
        end else begin
          cnt_nxt = cinc;
          vp_nxt  = vp_r + (PG_W + 1)'(1);
        end
      end
      S_MV_ISS: begin
        if (mpg_r == (PG_W + 1)'(PAGES_PER_BLOCK)) begin
          mpg_nxt   = '0;
          state_nxt = S_ER_ISS;
        end else begin
          ps_raddr  = phys_addr(32'(vic_r), 32'(mpg_r));
          rv_raddr  = ps_raddr;
          state_nxt = S_MV_CHK;
        end
      end
      S_MV_CHK: begin
        if (ps_rd == PS_VALID) begin
          own_nxt   = rv_rd;
          fb_nxt    = '0;
          fp_nxt    = '0;
          skip_nxt  = 1'b1;
          ctx_nxt   = CTX_GC;
          state_nxt = S_FF_ISS;
        end else begin
          mpg_nxt   = mpg_r + (PG_W + 1)'(1);
          state_nxt = S_MV_ISS;
        end
      end
      S_MV_DO: begin
        if (out_free) begin
          ps_we     = 1'b1;
          ps_waddr  = phys_addr(32'(dst_r.blk), 32'(dst_r.pg));
          ps_wdata  = PS_VALID;
          rv_we     = 1'b1;
          rv_waddr  = ps_waddr;
          rv_wdata  = own_r;
          mp_we     = 1'b1;
          mp_waddr  = own_r;
          mp_wdata  = dst_r;
          emit      = 1'b1;
          e_kind    = RK_MOVE;
          e_stat    = ST_OK;
          e_blk     = nib(32'(dst_r.blk));
          e_pg      = nib(32'(dst_r.pg));
          e_sblk    = nib(32'(vic_r));
          e_spg     = nib(32'(mpg_r));
          state_nxt = S_MV_SRC;
        end
      end
      S_MV_SRC: begin
        ps_we     = 1'b1;
        ps_waddr  = phys_addr(32'(vic_r), 32'(mpg_r));
        ps_wdata  = PS_INVALID;
        mpg_nxt   = mpg_r + (PG_W + 1)'(1);
        state_nxt = S_MV_ISS;
      end
      S_ER_ISS: begin
        if (mpg_r == (PG_W + 1)'(PAGES_PER_BLOCK)) begin
          state_nxt = S_ER_EMIT;
        end else begin
          ps_raddr  = phys_addr(32'(vic_r), 32'(mpg_r));
          rv_raddr  = ps_raddr;
          state_nxt = S_ER_CHK;
        end
      end
      S_ER_CHK: begin
        if (ps_rd == PS_VALID) begin
          mval_nxt[rv_rd] = 1'b0;
        end
        ps_we     = 1'b1;
        ps_waddr  = phys_addr(32'(vic_r), 32'(mpg_r));
        ps_wdata  = PS_FREE;
        mpg_nxt   = mpg_r + (PG_W + 1)'(1);
        state_nxt = S_ER_ISS;
      end
      S_ER_EMIT: begin
        if (out_free) begin
          emit      = 1'b1;
          e_kind    = RK_ERASE;
          e_stat    = ST_OK;
          e_blk     = nib(32'(vic_r));
          fb_nxt    = '0;
          fp_nxt    = '0;
          skip_nxt  = 1'b0;
          ctx_nxt   = CTX_W2;
          state_nxt = S_FF_ISS;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    ov_nxt  = ov_r && out_stall;
    ok_nxt  = ok_r;
    os_nxt  = os_r;
    ob_nxt  = ob_r;
    op_nxt  = op_r;
    osb_nxt = osb_r;
    osp_nxt = osp_r;
    ol_nxt  = ol_r;
    if (emit) begin
      ov_nxt  = 1'b1;
      ok_nxt  = e_kind;
      os_nxt  = e_stat;
      ob_nxt  = e_blk;
      op_nxt  = e_pg;
      osb_nxt = e_sblk;
      osp_nxt = e_spg;
      ol_nxt  = e_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      clr_r   <= '0;
      mval_r  <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      mval_r  <= mval_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ctx_r   <= ctx_nxt;
    kind_r  <= kind_nxt;
    lp_r    <= lp_nxt;
    fb_r    <= fb_nxt;
    fp_r    <= fp_nxt;
    skip_r  <= skip_nxt;
    dst_r   <= dst_nxt;
    vb_r    <= vb_nxt;
    vp_r    <= vp_nxt;
    cnt_r   <= cnt_nxt;
    best_r  <= best_nxt;
    vic_r   <= vic_nxt;
    first_r <= first_nxt;
    mpg_r   <= mpg_nxt;
    own_r   <= own_nxt;
    ok_r    <= ok_nxt;
    os_r    <= os_nxt;
    ob_r    <= ob_nxt;
    op_r    <= op_nxt;
    osb_r   <= osb_nxt;
    osp_r   <= osp_nxt;
    ol_r    <= ol_nxt;
  end

  assign out_valid        = ov_r;
  assign out_result_kind  = ok_r;
  assign out_status       = os_r;
  assign out_phys_block   = ob_r;
  assign out_phys_page    = op_r;
  assign out_source_block = osb_r;
  assign out_source_page  = osp_r;
  assign out_last         = ol_r;
endmodule

// ----- tb/sv/ftl_page_map_greedy_gc_tb.sv -----
module ftl_page_map_greedy_gc_tb;
  import ftlgc_pkg::*;

  typedef struct packed {
    rkind_t     rk;
    status_t    st;
    logic [3:0] pb;
    logic [3:0] pp;
    logic [3:0] sb;
    logic [3:0] sp;
    logic       last;
  } ftl_res_t;

  class ftl_scoreboard;
    bit        map_ok [LOGICAL_PAGES];
    int        map_loc [LOGICAL_PAGES];
    pstat_t    pstat [PHYS_PAGES];
    ftl_res_t  pending [$];
    int        errors;
    int        checked;
    int        moves;
    int        erases;
    int        nofree;

    function void clear();
      foreach (map_ok[i]) map_ok[i] = 0;
      foreach (map_loc[i]) map_loc[i] = 0;
      foreach (pstat[i]) pstat[i] = PS_FREE;
      pending.delete();
      errors = 0;
      checked = 0;
      moves = 0;
      erases = 0;
      nofree = 0;
    endfunction

    function void push(rkind_t rk, status_t st, int pb, int pp, int sb, int sp, bit last);
      ftl_res_t r;
      r.rk = rk;
      r.st = st;
      r.pb = pb[3:0];
      r.pp = pp[3:0];
      r.sb = sb[3:0];
      r.sp = sp[3:0];
      r.last = last;
      pending.push_back(r);
    endfunction

    function int lowest_free(int skip);
      for (int b = 0; b < BLOCK_COUNT; b++) begin
        if (b == skip) continue;
        for (int p = 0; p < PAGES_PER_BLOCK; p++)
          if (pstat[b * PAGES_PER_BLOCK + p] == PS_FREE) return b * PAGES_PER_BLOCK + p;
      end
      return -1;
    endfunction

    function void collect();
      int victim;
      int most;
      int n;
      int src;
      int dst;
      victim = 0;
      most = -1;
      for (int b = 0; b < BLOCK_COUNT; b++) begin
        n = 0;
        for (int p = 0; p < PAGES_PER_BLOCK; p++)
          if (pstat[b * PAGES_PER_BLOCK + p] == PS_INVALID) n++;
        if (n > most) begin
          most = n;
          victim = b;
        end
      end
      for (int p = 0; p < PAGES_PER_BLOCK; p++) begin
        src = victim * PAGES_PER_BLOCK + p;
        if (pstat[src] != PS_VALID) continue;
        dst = lowest_free(victim);
        if (dst < 0) continue;
        pstat[dst] = PS_VALID;
        for (int l = 0; l < LOGICAL_PAGES; l++)
          if (map_ok[l] && map_loc[l] == src) map_loc[l] = dst;
        pstat[src] = PS_INVALID;
        push(RK_MOVE, ST_OK, dst / PAGES_PER_BLOCK, dst % PAGES_PER_BLOCK, victim, p, 0);
        moves++;
      end
      for (int l = 0; l < LOGICAL_PAGES; l++)
        if (map_ok[l] && map_loc[l] / PAGES_PER_BLOCK == victim
            && pstat[map_loc[l]] == PS_VALID)
          map_ok[l] = 0;
      for (int p = 0; p < PAGES_PER_BLOCK; p++)
        pstat[victim * PAGES_PER_BLOCK + p] = PS_FREE;
      push(RK_ERASE, ST_OK, victim, 0, 0, 0, 0);
      erases++;
    endfunction

    function void note_request(logic kind, logic [7:0] lpage);
      int l;
      int idx;
      l = lpage;
      if (kind == KIND_READ) begin
        if (l >= LOGICAL_PAGES) push(RK_READ, ST_RANGE, 0, 0, 0, 0, 1);
        else if (!map_ok[l]) push(RK_READ, ST_UNMAP, 0, 0, 0, 0, 1);
        else push(RK_READ, ST_OK, map_loc[l] / PAGES_PER_BLOCK,
                  map_loc[l] % PAGES_PER_BLOCK, 0, 0, 1);
        return;
      end
      if (l >= LOGICAL_PAGES) begin
        push(RK_WRITE, ST_RANGE, 0, 0, 0, 0, 1);
        return;
      end
      if (map_ok[l]) pstat[map_loc[l]] = PS_INVALID;
      map_ok[l] = 0;
      idx = lowest_free(BLOCK_COUNT);
      if (idx < 0) begin
        collect();
        idx = lowest_free(BLOCK_COUNT);
        if (idx < 0) begin
          push(RK_WRITE, ST_NOFREE, 0, 0, 0, 0, 1);
          nofree++;
          return;
        end
      end
      pstat[idx] = PS_VALID;
      map_ok[l] = 1;
      map_loc[l] = idx;
      push(RK_WRITE, ST_OK, idx / PAGES_PER_BLOCK, idx % PAGES_PER_BLOCK, 0, 0, 1);
    endfunction

    function void check_result(ftl_res_t got);
      ftl_res_t exp;
      if (pending.size() == 0) begin
        $error("unexpected result kind=%0d", got.rk);
        errors++;
        return;
      end
      exp = pending.pop_front();
      checked++;
      if (got.rk != exp.rk) begin
        $error("result_kind expected %0d actual %0d", exp.rk, got.rk); errors++;
      end
      if (got.st != exp.st) begin
        $error("status expected %0d actual %0d", exp.st, got.st); errors++;
      end
      if (got.pb != exp.pb) begin
        $error("phys_block expected %0d actual %0d", exp.pb, got.pb); errors++;
      end
      if (got.pp != exp.pp) begin
        $error("phys_page expected %0d actual %0d", exp.pp, got.pp); errors++;
      end
      if (got.sb != exp.sb) begin
        $error("source_block expected %0d actual %0d", exp.sb, got.sb); errors++;
      end
      if (got.sp != exp.sp) begin
        $error("source_page expected %0d actual %0d", exp.sp, got.sp); errors++;
      end
      if (got.last != exp.last) begin
        $error("last expected %0d actual %0d", exp.last, got.last); errors++;
      end
    endfunction
  endclass

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic       in_kind;
  logic [7:0] in_logical_page;
  logic       out_valid;
  logic       out_stall;
  logic [1:0] out_result_kind;
  logic [1:0] out_status;
  logic [3:0] out_phys_block;
  logic [3:0] out_phys_page;
  logic [3:0] out_source_block;
  logic [3:0] out_source_page;
  logic       out_last;

  ftl_scoreboard sb;
  int  sent;
  bit  quiet;
  bit  hold_long;

  ftl_page_map_greedy_gc u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_kind(in_kind), .in_logical_page(in_logical_page),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_result_kind(out_result_kind), .out_status(out_status),
    .out_phys_block(out_phys_block), .out_phys_page(out_phys_page),
    .out_source_block(out_source_block), .out_source_page(out_source_page),
    .out_last(out_last)
  );

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  initial begin
    #100000000;
    $display("RESULT: ERROR");
    $finish;
  end

  // one request; keeps valid high when the next one follows without a gap
  task automatic send_request(logic kind, logic [7:0] lpage);
    int gap;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 12);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_kind <= kind;
    in_logical_page <= lpage;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_request(kind, lpage);
    sent++;
  endtask

  task automatic random_request();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) send_request(1'b1, 8'($urandom_range(0, 23)));
    else if (r < 70) send_request(1'b1, 8'($urandom_range(0, 63)));
    else if (r < 88) send_request(1'b0, 8'($urandom_range(0, 63)));
    else send_request(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
  endtask

  // receiver side: random stall bursts, plus one long hold
  initial begin
    int n;
    out_stall = 1'b0;
    @(posedge rst_n);
    forever begin
      if (hold_long) begin
        out_stall <= 1'b1;
        repeat (3000) @(posedge clk);
        out_stall <= 1'b0;
        hold_long = 0;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 12);
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    ftl_res_t got;
    if (rst_n && out_valid && !out_stall) begin
      got.rk = rkind_t'(out_result_kind);
      got.st = status_t'(out_status);
      got.pb = out_phys_block;
      got.pp = out_phys_page;
      got.sb = out_source_block;
      got.sp = out_source_page;
      got.last = out_last;
      sb.check_result(got);
    end
  end

  initial begin
    int waited;
    sb = new();
    sb.clear();
    sent = 0;
    quiet = 0;
    hold_long = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_kind = 1'b0;
    in_logical_page = 8'd0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // directed: ranges, unmapped, rewrite, extremes
    send_request(1'b0, 8'd0);
    send_request(1'b0, 8'd63);
    send_request(1'b0, 8'd64);
    send_request(1'b0, 8'd255);
    send_request(1'b1, 8'd255);
    send_request(1'b1, 8'd64);
    send_request(1'b1, 8'd0);
    send_request(1'b1, 8'd63);
    send_request(1'b0, 8'd0);
    send_request(1'b0, 8'd63);
    send_request(1'b1, 8'd0);
    send_request(1'b0, 8'd0);
    send_request(1'b1, 8'd170);
    send_request(1'b1, 8'd42);
    send_request(1'b1, 8'd21);
    send_request(1'b0, 8'd42);

    // long receiver hold while requests keep coming
    hold_long = 1;
    repeat (30) random_request();

    while (sent < 310) random_request();
    quiet = 1;
    while (sent < 370) random_request();
    in_valid <= 1'b0;

    waited = 0;
    while (sb.pending.size() != 0 && waited < 200000) begin
      @(posedge clk);
      waited++;
    end
    repeat (2000) @(posedge clk);
    $display("covered %0d requests, %0d results: %0d gc moves, %0d erases, %0d no-free",
             sent, sb.checked, sb.moves, sb.erases, sb.nofree);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
